>>> rtl/planar_odometry_integrator_macros.svh
// Assertion macros used by the checker of the odometry integrator
`ifndef PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define POI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometry integrator check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define POI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometry integrator check failed");

`endif

>>> rtl/poi_pkg.sv
// Types, constants and tables shared by the odometry integrator modules
package poi_pkg;

    // Stream widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_W  = 88;
    localparam int OUT_W = 136;

    // Register indexes on the configuration port
    localparam logic REG_DT_LIMIT    = 1'b0;
    localparam logic REG_SPEED_LIMIT = 1'b1;

    localparam logic [19:0] DT_LIMIT_RST    = 20'd100000;
    localparam logic [14:0] SPEED_LIMIT_RST = 15'd10000;

    // Heading reduction, hundredths of a degree
    localparam logic signed [18:0] ANG_FULL    = 19'sd36000;
    localparam logic signed [18:0] ANG_NFULL   = -19'sd36000;
    localparam logic signed [18:0] ANG_TWO     = 19'sd72000;
    localparam logic signed [18:0] ANG_HALF    = 19'sd18000;
    localparam logic signed [18:0] ANG_QUART   = 19'sd9000;
    localparam logic signed [18:0] ANG_NQUART  = -19'sd9000;

    // Hundredths of a degree to Q2.30 radians: pi*2^30/18000 = 187403 + 5426/18000
    localparam logic signed [22:0] RAD_WHOLE   = 23'sd187403;
    localparam logic signed [22:0] RAD_FRAC    = 23'sd5426;
    localparam logic [25:0]        RAD_RND     = 26'd9000;
    // ceil(2^32/1125): exact quotient by 1125 for operands below 2^22
    localparam logic signed [22:0] RECIP_1125  = 23'sd3817749;

    // CORDIC start vector (gain 0.60725 in Q1.15) and unit clamp
    localparam logic signed [17:0] CORDIC_X0   = 18'sd19898;
    localparam logic signed [17:0] UNIT_MAX    = 18'sd32767;
    localparam logic signed [17:0] UNIT_MIN    = -18'sd32767;
    localparam int                 ATAN_LEN    = 24;

    // Rounding offset for the Q15 velocity products
    localparam logic signed [33:0] Q15_RND     = 34'sd16384;

    typedef enum logic [4:0] {
        ST_IDLE, ST_GATE,
        ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_Q4,
        ST_ROT, ST_CLAMP,
        ST_V0, ST_V1, ST_V2, ST_V3, ST_V4,
        ST_P0, ST_P1, ST_P2,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_FRAC, MUL_RECIP, MUL_WHOLE,
        MUL_VXC, MUL_VYS, MUL_VXS, MUL_VYC,
        MUL_PX, MUL_PY
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     gate;
        mul_sel_t mul_sel;
        logic     num_ld;
        logic     quo_ld;
        logic     z_ld;
        logic     rot_step;
        logic     clamp;
        logic     acc_ld;
        logic     wvx_ld;
        logic     wvy_ld;
        logic     posx_ld;
        logic     posy_ld;
        logic     out_ld;
    } dp_cmd_t;

    typedef struct packed {
        logic go;
        logic rot_last;
    } dp_stat_t;

    // Arctangent of 2^-i in Q2.30
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Clamp a 49-bit sum into the 48-bit signed position range
    function automatic logic [47:0] sat48(input logic signed [48:0] v);
        logic [47:0] r;
        if (v[48] != v[47])
        begin
            r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/poi_ctrl.sv
// Sequencer of the odometry integrator: item handshake, step order, result slot
module poi_ctrl
    import poi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_GATE;
            ST_GATE:  state_next = ST_Q0;
            ST_Q0:    state_next = stat.go ? ST_Q1 : ST_DONE;
            ST_Q1:    state_next = ST_Q2;
            ST_Q2:    state_next = ST_Q3;
            ST_Q3:    state_next = ST_Q4;
            ST_Q4:    state_next = ST_ROT;
            ST_ROT:   if (stat.rot_last) state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_V0;
            ST_V0:    state_next = ST_V1;
            ST_V1:    state_next = ST_V2;
            ST_V2:    state_next = ST_V3;
            ST_V3:    state_next = ST_V4;
            ST_V4:    state_next = ST_P0;
            ST_P0:    state_next = ST_P1;
            ST_P1:    state_next = ST_P2;
            ST_P2:    state_next = ST_DONE;
            ST_DONE:  if (slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MUL_NONE;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_GATE:  cmd.gate = 1'b1;
            ST_Q0:    cmd.mul_sel = MUL_FRAC;
            ST_Q1:    cmd.num_ld = 1'b1;
            ST_Q2:    cmd.mul_sel = MUL_RECIP;
            ST_Q3:
            begin
                cmd.quo_ld  = 1'b1;
                cmd.mul_sel = MUL_WHOLE;
            end
            ST_Q4:    cmd.z_ld = 1'b1;
            ST_ROT:   cmd.rot_step = 1'b1;
            ST_CLAMP: cmd.clamp = 1'b1;
            ST_V0:    cmd.mul_sel = MUL_VXC;
            ST_V1:
            begin
                cmd.acc_ld  = 1'b1;
                cmd.mul_sel = MUL_VYS;
            end
            ST_V2:
            begin
                cmd.wvx_ld  = 1'b1;
                cmd.mul_sel = MUL_VXS;
            end
            ST_V3:
            begin
                cmd.acc_ld  = 1'b1;
                cmd.mul_sel = MUL_VYC;
            end
            ST_V4:    cmd.wvy_ld = 1'b1;
            ST_P0:    cmd.mul_sel = MUL_PX;
            ST_P1:
            begin
                cmd.posx_ld = 1'b1;
                cmd.mul_sel = MUL_PY;
            end
            ST_P2:    cmd.posy_ld = 1'b1;
            ST_DONE:  cmd.out_ld = slot_free;
            default:  cmd = '0;
        endcase
    end

    // Result slot: fill on load, drain on an accepted output beat
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_ld)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/poi_dp.sv
// Datapath of the odometry integrator: gates, heading, CORDIC, shared multiplier
module poi_dp
    import poi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic [19:0]      dt_limit,
    input  logic [14:0]      speed_limit,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tuser
);

    localparam int ROT_N = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int ITW   = (ROT_N > 1) ? $clog2(ROT_N) : 1;

    // Input item
    logic [31:0]        ts_reg,  ts_next;
    logic signed [15:0] vx_reg,  vx_next;
    logic signed [15:0] vy_reg,  vy_next;
    logic signed [16:0] yaw_reg, yaw_next;

    // Gate results and heading
    logic               go_reg,      go_next;
    logic [19:0]        elapsed_reg, elapsed_next;
    logic [13:0]        mag_reg,     mag_next;
    logic               zneg_reg,    zneg_next;
    logic               fneg_reg,    fneg_next;

    // Shared multiplier and angle conversion
    logic signed [45:0] prod_reg, prod_next;
    logic [25:0]        num_reg,  num_next;
    logic [11:0]        quo_reg,  quo_next;

    // CORDIC
    logic signed [17:0] x_reg, x_next;
    logic signed [17:0] y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic [ITW-1:0]     iter_reg, iter_next;
    logic signed [15:0] c_reg, c_next;
    logic signed [15:0] s_reg, s_next;

    // Velocity products
    logic signed [33:0] acc_reg, acc_next;

    // Odometry state
    logic signed [47:0] pos_x_reg, pos_x_next;
    logic signed [47:0] pos_y_reg, pos_y_next;
    logic signed [16:0] vel_x_reg, vel_x_next;
    logic signed [16:0] vel_y_reg, vel_y_next;
    logic [31:0]        prev_time_reg, prev_time_next;
    logic               prev_valid_reg, prev_valid_next;

    // Result register
    logic [OUT_W-1:0]   out_data_reg, out_data_next;
    logic               out_user_reg, out_user_next;

    // Combinational terms
    logic [31:0]        elapsed;
    logic               time_ok, dt_ok, spd_ok;
    logic signed [16:0] lim17, vx17, vy17;
    logic signed [18:0] yaw19, a0, a1, a2;
    logic               fold;
    logic signed [22:0] mul_a, mul_b;
    logic signed [45:0] mul_p;
    logic [30:0]        zmag;
    logic signed [17:0] xs, ys;
    logic signed [32:0] at33;
    logic signed [17:0] cx, sy;
    logic signed [33:0] vsum;
    logic signed [48:0] psum;

    // Gate checks
    assign elapsed = ts_reg - prev_time_reg;
    assign time_ok = prev_valid_reg && (ts_reg >= prev_time_reg);
    assign dt_ok   = elapsed < {12'd0, dt_limit};
    assign lim17   = $signed({2'b00, speed_limit});
    assign vx17    = {vx_reg[15], vx_reg};
    assign vy17    = {vy_reg[15], vy_reg};
    assign spd_ok  = (vx17 < lim17) && (vx17 > -lim17) && (vy17 < lim17) && (vy17 > -lim17);

    // Heading: reduce to [0,360), then to (-180,180], then fold to [-90,90]
    assign yaw19 = {{2{yaw_reg[16]}}, yaw_reg};
    always_comb
    begin
        if (yaw19 >= ANG_FULL)
        begin
            a0 = yaw19 - ANG_FULL;
        end
        else if (yaw19 >= 19'sd0)
        begin
            a0 = yaw19;
        end
        else if (yaw19 >= ANG_NFULL)
        begin
            a0 = yaw19 + ANG_FULL;
        end
        else
        begin
            a0 = yaw19 + ANG_TWO;
        end
        a1 = (a0 > ANG_HALF) ? (a0 - ANG_FULL) : a0;
        if (a1 > ANG_QUART)
        begin
            a2   = a1 - ANG_HALF;
            fold = 1'b1;
        end
        else if (a1 < ANG_NQUART)
        begin
            a2   = a1 + ANG_HALF;
            fold = 1'b1;
        end
        else
        begin
            a2   = a1;
            fold = 1'b0;
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_FRAC:
            begin
                mul_a = $signed({9'd0, mag_reg});
                mul_b = RAD_FRAC;
            end
            MUL_RECIP:
            begin
                mul_a = $signed({1'b0, num_reg[25:4]});
                mul_b = RECIP_1125;
            end
            MUL_WHOLE:
            begin
                mul_a = $signed({9'd0, mag_reg});
                mul_b = RAD_WHOLE;
            end
            MUL_VXC:
            begin
                mul_a = {{7{vx_reg[15]}}, vx_reg};
                mul_b = {{7{c_reg[15]}}, c_reg};
            end
            MUL_VYS:
            begin
                mul_a = {{7{vy_reg[15]}}, vy_reg};
                mul_b = {{7{s_reg[15]}}, s_reg};
            end
            MUL_VXS:
            begin
                mul_a = {{7{vx_reg[15]}}, vx_reg};
                mul_b = {{7{s_reg[15]}}, s_reg};
            end
            MUL_VYC:
            begin
                mul_a = {{7{vy_reg[15]}}, vy_reg};
                mul_b = {{7{c_reg[15]}}, c_reg};
            end
            MUL_PX:
            begin
                mul_a = {{6{vel_x_reg[16]}}, vel_x_reg};
                mul_b = $signed({3'd0, elapsed_reg});
            end
            MUL_PY:
            begin
                mul_a = {{6{vel_y_reg[16]}}, vel_y_reg};
                mul_b = $signed({3'd0, elapsed_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // CORDIC step terms; arithmetic shifts floor
    assign xs   = x_reg >>> iter_reg;
    assign ys   = y_reg >>> iter_reg;
    assign at33 = $signed({3'd0, atan_q30(5'(iter_reg))});
    assign zmag = prod_reg[30:0] + {19'd0, quo_reg};

    // Clamp the rotated vector to the Q1.15 unit range
    assign cx = (x_reg > UNIT_MAX) ? UNIT_MAX : ((x_reg < UNIT_MIN) ? UNIT_MIN : x_reg);
    assign sy = (y_reg > UNIT_MAX) ? UNIT_MAX : ((y_reg < UNIT_MIN) ? UNIT_MIN : y_reg);

    // Velocity rounding sum and position sum
    assign vsum = cmd.wvx_ld ? (acc_reg - prod_reg[33:0] + Q15_RND)
                             : (acc_reg + prod_reg[33:0] + Q15_RND);
    assign psum = cmd.posx_ld ? ({pos_x_reg[47], pos_x_reg} + {{3{prod_reg[45]}}, prod_reg})
                              : ({pos_y_reg[47], pos_y_reg} + {{3{prod_reg[45]}}, prod_reg});

    // Next values
    always_comb
    begin
        ts_next         = ts_reg;
        vx_next         = vx_reg;
        vy_next         = vy_reg;
        yaw_next        = yaw_reg;
        go_next         = go_reg;
        elapsed_next    = elapsed_reg;
        mag_next        = mag_reg;
        zneg_next       = zneg_reg;
        fneg_next       = fneg_reg;
        prod_next       = prod_reg;
        num_next        = num_reg;
        quo_next        = quo_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        iter_next       = iter_reg;
        c_next          = c_reg;
        s_next          = s_reg;
        acc_next        = acc_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        vel_x_next      = vel_x_reg;
        vel_y_next      = vel_y_reg;
        prev_time_next  = prev_time_reg;
        prev_valid_next = prev_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;

        // Capture the input beat
        if (cmd.load)
        begin
            ts_next  = s_tdata[31:0];
            vx_next  = s_tdata[47:32];
            vy_next  = s_tdata[63:48];
            yaw_next = s_tdata[80:64];
        end

        // Evaluate gates, fold the heading, store the timestamp
        if (cmd.gate)
        begin
            go_next         = time_ok && dt_ok && spd_ok;
            elapsed_next    = elapsed[19:0];
            zneg_next       = a2[18];
            fneg_next       = fold;
            mag_next        = a2[18] ? 14'(-a2) : a2[13:0];
            prev_time_next  = ts_reg;
            prev_valid_next = 1'b1;
        end

        if (cmd.mul_sel != MUL_NONE)
        begin
            prod_next = mul_p;
        end

        // Radian conversion: fraction numerator, then quotient
        if (cmd.num_ld)
        begin
            num_next = prod_reg[25:0] + RAD_RND;
        end
        if (cmd.quo_ld)
        begin
            quo_next = prod_reg[43:32];
        end

        // Start the rotation
        if (cmd.z_ld)
        begin
            z_next    = zneg_reg ? -$signed({2'b00, zmag}) : $signed({2'b00, zmag});
            x_next    = CORDIC_X0;
            y_next    = '0;
            iter_next = '0;
        end

        // One CORDIC micro-rotation
        if (cmd.rot_step)
        begin
            if (!z_reg[32])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at33;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at33;
            end
            iter_next = iter_reg + 1'b1;
        end

        // Clamp and undo the half-turn fold
        if (cmd.clamp)
        begin
            c_next = fneg_reg ? -cx[15:0] : cx[15:0];
            s_next = fneg_reg ? -sy[15:0] : sy[15:0];
        end

        if (cmd.acc_ld)
        begin
            acc_next = prod_reg[33:0];
        end
        if (cmd.wvx_ld)
        begin
            vel_x_next = vsum[31:15];
        end
        if (cmd.wvy_ld)
        begin
            vel_y_next = vsum[31:15];
        end

        // Accumulate displacement with saturation
        if (cmd.posx_ld)
        begin
            pos_x_next = sat48(psum);
        end
        if (cmd.posy_ld)
        begin
            pos_y_next = sat48(psum);
        end

        // Load the result beat
        if (cmd.out_ld)
        begin
            out_data_next = {6'd0, vel_y_reg, vel_x_reg, pos_y_reg, pos_x_reg};
            out_user_next = go_reg;
        end
    end

    // Odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            vel_x_reg      <= '0;
            vel_y_reg      <= '0;
            prev_time_reg  <= '0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            vel_x_reg      <= vel_x_next;
            vel_y_reg      <= vel_y_next;
            prev_time_reg  <= prev_time_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        ts_reg       <= ts_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        yaw_reg      <= yaw_next;
        go_reg       <= go_next;
        elapsed_reg  <= elapsed_next;
        mag_reg      <= mag_next;
        zneg_reg     <= zneg_next;
        fneg_reg     <= fneg_next;
        prod_reg     <= prod_next;
        num_reg      <= num_next;
        quo_reg      <= quo_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        iter_reg     <= iter_next;
        c_reg        <= c_next;
        s_reg        <= s_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign stat.go       = go_reg;
    assign stat.rot_last = (iter_reg == ITW'(ROT_N - 1));
    assign m_tdata       = out_data_reg;
    assign m_tuser       = out_user_reg;

endmodule

>>> rtl/planar_odometry_integrator.sv
// Top level of the planar odometry integrator: config registers, sequencer, datapath
//
// Input stream (s_*): one beat per odometry sample: timestamp in us, body
// velocities in mm/s and heading in hundredths of a degree.
// Output stream (m_*): one beat per input beat: saturated x/y position in nm,
// last world-frame velocity, and m_tuser high when the sample passed the gates and was integrated.
// APB port: dt_limit_us at 0x0, speed_limit at 0x4; write only while idle.
// Sequence: a passing item goes from GATE through the Q0-Q4 radian conversion,
// the CORDIC rotation, CLAMP, V0-V4 velocity and P0-P2 position steps to DONE,
// where its result is loaded; a failing item goes from Q0 straight to DONE. No
// new input beat is taken before the result is loaded; the block is ready again
// in the cycle after. The CORDIC loop, one micro-rotation per cycle, and the
// single shared 23x23 multiplier (nine uses per passing item) set the pace.
// Reset clears position, velocity and the stored timestamp; the first sample
// afterwards only records its time. A stalled receiver holds the result beat;
// one more item can be computed behind it and waits until the beat is taken.
module planar_odometry_integrator
    import poi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    // timestamp_us[31:0], body_vx[47:32], body_vy[63:48], yaw_angle[80:64], zero pad
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // pos_x[47:0], pos_y[95:48], world_vx[112:96], world_vy[129:113], zero pad
    output logic [OUT_W-1:0] m_tdata,
    // integrated[0]
    output logic             m_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [19:0] dt_limit_reg,    dt_limit_next;
    logic [14:0] speed_limit_reg, speed_limit_next;
    logic        cfg_wr;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes
    always_comb
    begin
        dt_limit_next    = dt_limit_reg;
        speed_limit_next = speed_limit_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_DT_LIMIT:    dt_limit_next    = pwdata[19:0];
                REG_SPEED_LIMIT: speed_limit_next = pwdata[14:0];
                default:         dt_limit_next    = dt_limit_reg;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (paddr[2])
            REG_DT_LIMIT:    prdata = {12'd0, dt_limit_reg};
            REG_SPEED_LIMIT: prdata = {17'd0, speed_limit_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_limit_reg    <= DT_LIMIT_RST;
            speed_limit_reg <= SPEED_LIMIT_RST;
        end
        else
        begin
            dt_limit_reg    <= dt_limit_next;
            speed_limit_reg <= speed_limit_next;
        end
    end

    poi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    poi_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .s_tdata     (s_tdata),
        .dt_limit    (dt_limit_reg),
        .speed_limit (speed_limit_reg),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

>>> rtl/poi_chk.sv
// Port-level checker for the odometry integrator, bound to the top level
`include "planar_odometry_integrator_macros.svh"

module poi_chk
    import poi_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser
);

    // One item at a time: input closes right after a beat is taken
    `POI_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

    // A fresh result appears as the block returns to idle
    `POI_ASSERT_SAME(a_result_idle, $rose(m_tvalid), s_tready)

    // A stalled result beat holds its payload
    `POI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind planar_odometry_integrator poi_chk u_poi_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
